// ===== design/aet_pkg.sv =====
// shared types and constants for the adsr envelope table entry block
package aet_pkg;

    localparam int unsigned IDX_W  = 8;
    localparam int unsigned AMP_W  = 8;
    localparam int unsigned GAIN_W = 16;
    localparam int unsigned OUT_W  = 16;
    localparam int unsigned NUM_W  = 2 * AMP_W;
    localparam int unsigned ADDR_W = 3;

    localparam logic [AMP_W-1:0] AMP_MAX = 8'hFF;
    localparam logic [IDX_W-1:0] LAST_INDEX = 8'hFF;

    // register indexes on the config port
    localparam logic [ADDR_W-1:0] REG_ATTACK_LEN    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_DECAY_LEN     = 3'd1;
    localparam logic [ADDR_W-1:0] REG_SUSTAIN_LEVEL = 3'd2;
    localparam logic [ADDR_W-1:0] REG_RELEASE_LEN   = 3'd3;
    localparam logic [ADDR_W-1:0] REG_GAIN_FACTOR   = 3'd4;

    // reset values of the registers
    localparam logic [AMP_W-1:0]  RST_ATTACK_LEN    = 8'd0;
    localparam logic [AMP_W-1:0]  RST_DECAY_LEN     = 8'd0;
    localparam logic [AMP_W-1:0]  RST_SUSTAIN_LEVEL = 8'd255;
    localparam logic [AMP_W-1:0]  RST_RELEASE_LEN   = 8'd0;
    localparam logic [GAIN_W-1:0] RST_GAIN_FACTOR   = 16'd256;

    // amp = sub ? base - num / den : base + num / den, quotient always below 256
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [AMP_W-1:0] den;
        logic [AMP_W-1:0] base;
        logic             sub;
    } t_div_req;

    // envelope settings handed from the register bank to the front
    typedef struct packed {
        logic [AMP_W-1:0] attack_len;
        logic [AMP_W-1:0] decay_len;
        logic [AMP_W-1:0] sustain_level;
        logic [AMP_W-1:0] release_len;
    } t_env_cfg;

endpackage

// ===== design/aet_front.sv =====
// front end: picks the envelope segment and forms the ramp division operands
module aet_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  aet_pkg::t_env_cfg       i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [aet_pkg::IDX_W-1:0] i_index,
    output logic                    o_req_vld,
    output aet_pkg::t_div_req       o_req,
    input  logic                    i_q_full
);
    import aet_pkg::*;

    logic             r_vld;
    t_div_req         r_req;
    t_div_req         n_req;
    logic [IDX_W-1:0] dec_stop;
    logic [IDX_W-1:0] sus_end;
    logic [AMP_W-1:0] mul_a;
    logic [AMP_W-1:0] mul_b;
    logic             push;
    logic             take;

    assign dec_stop = i_cfg.attack_len + i_cfg.decay_len;
    assign sus_end  = LAST_INDEX - i_cfg.release_len;

    always_comb begin
        n_req = '0;
        mul_a = '0;
        mul_b = '0;
        if (i_index < i_cfg.attack_len) begin
            // attack: i * 255 / attack_len
            mul_a      = i_index;
            mul_b      = AMP_MAX;
            n_req.den  = i_cfg.attack_len;
            n_req.base = '0;
            n_req.sub  = 1'b0;
        end else if (i_index < dec_stop) begin
            // decay: 255 - (255 - sustain) * (i - attack) / decay_len
            mul_a      = AMP_MAX - i_cfg.sustain_level;
            mul_b      = i_index - i_cfg.attack_len;
            n_req.den  = i_cfg.decay_len;
            n_req.base = AMP_MAX;
            n_req.sub  = 1'b1;
        end else if (i_index < sus_end || i_cfg.release_len == '0) begin
            // sustain, and the last index when release is zero
            n_req.den  = AMP_W'(1);
            n_req.base = i_cfg.sustain_level;
            n_req.sub  = 1'b0;
        end else begin
            // release: sustain - sustain * (i - sus_end) / release_len
            mul_a      = i_cfg.sustain_level;
            mul_b      = i_index - sus_end;
            n_req.den  = i_cfg.release_len;
            n_req.base = i_cfg.sustain_level;
            n_req.sub  = 1'b1;
        end
        n_req.num = NUM_W'(mul_a) * NUM_W'(mul_b);
    end

    assign push    = r_vld && !i_q_full;
    assign o_ready = !r_vld || !i_q_full;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= n_req;
        end
    end

    assign o_req_vld = r_vld;
    assign o_req     = r_req;

endmodule

// ===== design/aet_queue.sv =====
// short fifo between the front end and the divide pipeline
module aet_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  aet_pkg::t_div_req i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_vld,
    output aet_pkg::t_div_req o_data
);
    import aet_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_div_req        r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_vld   = r_cnt != '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== design/aet_back.sv =====
// back end: one quotient bit per stage, then offset, gain and output register
module aet_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [aet_pkg::GAIN_W-1:0] i_gain,
    input  logic                       i_req_vld,
    input  aet_pkg::t_div_req          i_req,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [aet_pkg::OUT_W-1:0]  o_value
);
    import aet_pkg::*;

    localparam int unsigned DSTG = AMP_W + 1;   // load stage plus one per quotient bit
    localparam int unsigned NSTG = DSTG + 2;    // then offset and gain stages
    localparam int unsigned PW   = AMP_W + GAIN_W;

    // restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [2*AMP_W-1:0] div_step(
        input logic [AMP_W-1:0] rem,
        input logic [AMP_W-1:0] work,
        input logic [AMP_W-1:0] den
    );
        logic [AMP_W:0] trial;
        logic [AMP_W:0] diff;
        logic           fits;
        trial = {rem, work[AMP_W-1]};
        diff  = trial - {1'b0, den};
        fits  = trial >= {1'b0, den};
        return fits ? {diff[AMP_W-1:0], work[AMP_W-2:0], 1'b1}
                    : {trial[AMP_W-1:0], work[AMP_W-2:0], 1'b0};
    endfunction

    logic [NSTG-1:0]  r_vld;
    logic [AMP_W-1:0] r_rem  [DSTG];
    logic [AMP_W-1:0] r_work [DSTG];
    logic [AMP_W-1:0] r_den  [DSTG];
    logic [AMP_W-1:0] r_base [DSTG];
    logic             r_sub  [DSTG];
    logic [AMP_W-1:0] r_amp;
    logic [OUT_W-1:0] r_out;
    logic [PW-1:0]    prod;
    logic             en;

    // whole pipe moves unless the output item is held
    assign en    = !r_vld[NSTG-1] || i_ready;
    assign o_pop = en;
    assign prod  = PW'(r_amp) * PW'(i_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_req_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0]  <= i_req.num[NUM_W-1:AMP_W];
            r_work[0] <= i_req.num[AMP_W-1:0];
            r_den[0]  <= i_req.den;
            r_base[0] <= i_req.base;
            r_sub[0]  <= i_req.sub;
            for (int k = 1; k < DSTG; k++) begin
                {r_rem[k], r_work[k]} <= div_step(r_rem[k-1], r_work[k-1], r_den[k-1]);
                r_den[k]  <= r_den[k-1];
                r_base[k] <= r_base[k-1];
                r_sub[k]  <= r_sub[k-1];
            end
            r_amp <= r_sub[DSTG-1] ? r_base[DSTG-1] - r_work[DSTG-1]
                                   : r_base[DSTG-1] + r_work[DSTG-1];
            // 255 * 65535 >> 8 stays below 65536, so no clamp is needed
            r_out <= prod[PW-1:AMP_W];
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_value = r_out;

endmodule

// ===== design/adsr_envelope_table_entry.sv =====
// top level of the linear adsr envelope table entry block
//
// each item on the input stream is a table index (0 to 255); for each one the
// block returns one 16-bit gained amplitude, (amp * gain_factor) >> 8, where
// amp follows a linear attack / decay / sustain / release shape set by the
// config registers. throughput is one item per clock while the output is not
// stalled: the ramp division is a restoring divider laid out as eight pipeline
// stages, one quotient bit each, so a new index can enter every cycle. the edge
// that accepts an index loads the front register; after it come the queue
// entry, a load stage, eight divide stages, the offset stage and the gain
// multiply into the output register. the front end and the divide
// pipe are joined by a small fifo, so a stall on the output only halts the
// input once that fifo is full. config registers are written through
// i_cfg_we / i_cfg_addr / i_cfg_wdata, index 0 attack_len, 1 decay_len,
// 2 sustain_level, 3 release_len, 4 gain_factor; other indexes are ignored.
// write them only while no item is in flight.
module adsr_envelope_table_entry #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] table_index
    // result items
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,   // [15:0] envelope_value
    // config writes
    input  logic                        i_cfg_we,
    input  logic [aet_pkg::ADDR_W-1:0]  i_cfg_addr,
    input  logic [aet_pkg::GAIN_W-1:0]  i_cfg_wdata
);
    import aet_pkg::*;

    // config registers
    logic [AMP_W-1:0]  r_attack_len;
    logic [AMP_W-1:0]  r_decay_len;
    logic [AMP_W-1:0]  r_sustain_level;
    logic [AMP_W-1:0]  r_release_len;
    logic [GAIN_W-1:0] r_gain_factor;

    t_env_cfg env_cfg;
    t_div_req front_req;
    t_div_req queue_req;
    logic     front_vld;
    logic     q_full;
    logic     q_vld;
    logic     back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_len    <= RST_ATTACK_LEN;
            r_decay_len     <= RST_DECAY_LEN;
            r_sustain_level <= RST_SUSTAIN_LEVEL;
            r_release_len   <= RST_RELEASE_LEN;
            r_gain_factor   <= RST_GAIN_FACTOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ATTACK_LEN:    r_attack_len    <= i_cfg_wdata[AMP_W-1:0];
                REG_DECAY_LEN:     r_decay_len     <= i_cfg_wdata[AMP_W-1:0];
                REG_SUSTAIN_LEVEL: r_sustain_level <= i_cfg_wdata[AMP_W-1:0];
                REG_RELEASE_LEN:   r_release_len   <= i_cfg_wdata[AMP_W-1:0];
                REG_GAIN_FACTOR:   r_gain_factor   <= i_cfg_wdata;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    always_comb begin
        env_cfg.attack_len    = r_attack_len;
        env_cfg.decay_len     = r_decay_len;
        env_cfg.sustain_level = r_sustain_level;
        env_cfg.release_len   = r_release_len;
    end

    // segment select and division operands, one register stage
    aet_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (env_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_index   (s_axis_tdata[IDX_W-1:0]),
        .o_req_vld (front_vld),
        .o_req     (front_req),
        .i_q_full  (q_full)
    );

    // decouples the front from stalls in the divide pipe
    aet_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_data  (front_req),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_vld   (q_vld),
        .o_data  (queue_req)
    );

    // divide, offset, gain and output register
    aet_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_gain    (r_gain_factor),
        .i_req_vld (q_vld),
        .i_req     (queue_req),
        .o_pop     (back_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_value   (m_axis_tdata)
    );

endmodule

// ===== design/aet_checker.sv =====
// port level checks for the adsr envelope table entry block, bound to the top
module aet_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [15:0]                 m_axis_tdata
);

    // no result is shown in the cycle after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // 255 times the largest gain, shifted by 8, never passes 65280
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata <= 16'd65280)
        else $error("result above full-scale gain");

    // a result cannot appear in the first cycles after reset, the pipe is deep
    a_latency: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |=> !m_axis_tvalid)
        else $error("result too soon after reset");

endmodule

bind adsr_envelope_table_entry aet_checker u_aet_checker (.*);

// ===== verif/tb_adsr_envelope_table_entry.sv =====
// testbench for the adsr envelope table entry block: directed and random indexes, scoreboard check
`timescale 1ns / 1ps

module tb_adsr_envelope_table_entry;

    import aet_pkg::*;

    localparam int unsigned CLK_HALF      = 6;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS   = 100;
    localparam int unsigned TAIL_CYCLES   = 32;
    localparam int unsigned CYCLE_LIMIT   = 300000;

    // indexes past the last register, writes there must not change anything
    localparam logic [ADDR_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    // holds the envelope settings and the queue of gained values still owed
    class envelope_scoreboard;
        logic [AMP_W-1:0]  attack_len;
        logic [AMP_W-1:0]  decay_len;
        logic [AMP_W-1:0]  sustain_level;
        logic [AMP_W-1:0]  release_len;
        logic [GAIN_W-1:0] gain_factor;
        logic [OUT_W-1:0]  owed_values[$];
        int unsigned       mismatches;

        function new();
            attack_len    = RST_ATTACK_LEN;
            decay_len     = RST_DECAY_LEN;
            sustain_level = RST_SUSTAIN_LEVEL;
            release_len   = RST_RELEASE_LEN;
            gain_factor   = RST_GAIN_FACTOR;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [ADDR_W-1:0] addr, logic [GAIN_W-1:0] data);
            case (addr)
                REG_ATTACK_LEN:    attack_len    = data[AMP_W-1:0];
                REG_DECAY_LEN:     decay_len     = data[AMP_W-1:0];
                REG_SUSTAIN_LEVEL: sustain_level = data[AMP_W-1:0];
                REG_RELEASE_LEN:   release_len   = data[AMP_W-1:0];
                REG_GAIN_FACTOR:   gain_factor   = data;
                default: ;
            endcase
        endfunction

        // 8-bit amplitude of the envelope at one table index
        function logic [AMP_W-1:0] amplitude_at(logic [IDX_W-1:0] idx);
            logic [IDX_W-1:0] dec_stop;
            logic [IDX_W-1:0] hold_stop;
            int unsigned i, a, d, s, r, amp;
            dec_stop  = attack_len + decay_len;     // wraps to 8 bits
            hold_stop = LAST_INDEX - release_len;
            i = idx;
            a = attack_len;
            d = decay_len;
            s = sustain_level;
            r = release_len;
            if (i < a) begin
                amp = (i * AMP_MAX) / a;
            end else if (i < dec_stop) begin
                // a <= i < dec_stop can only hold with a nonzero decay length
                amp = AMP_MAX - ((AMP_MAX - s) * (i - a)) / d;
            end else if (i < hold_stop || r == 0) begin
                // zero release length: the last index just holds sustain
                amp = s;
            end else begin
                amp = s - (s * (i - hold_stop)) / r;
            end
            return amp[AMP_W-1:0];
        endfunction

        function void note_index(logic [IDX_W-1:0] idx);
            int unsigned scaled;
            scaled = (amplitude_at(idx) * gain_factor) >> 8;
            if (scaled > 32'hFFFF) begin
                scaled = 32'hFFFF;
            end
            owed_values.push_back(scaled[OUT_W-1:0]);
        endfunction

        function void check_value(logic [OUT_W-1:0] actual);
            logic [OUT_W-1:0] expected;
            if (owed_values.size() == 0) begin
                $error("envelope_value: unexpected result, actual %0d", actual);
                mismatches++;
            end else begin
                expected = owed_values.pop_front();
                if (actual !== expected) begin
                    $error("envelope_value: expected %0d, actual %0d", expected, actual);
                    mismatches++;
                end
            end
        endfunction

        function bit waiting();
            return owed_values.size() != 0;
        endfunction

        function void flag_leftovers();
            if (owed_values.size() != 0) begin
                $error("envelope_value: %0d results never arrived", owed_values.size());
                mismatches += owed_values.size();
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;    // [7:0] table_index
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;    // [15:0] envelope_value
    logic              i_cfg_we;
    logic [ADDR_W-1:0] i_cfg_addr;
    logic [GAIN_W-1:0] i_cfg_wdata;

    envelope_scoreboard sb;
    int unsigned        src_idle_pct;
    int unsigned        sink_stall_pct;
    int unsigned        cycle_count;

    adsr_envelope_table_entry uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // receiver back-pressure, one decision per cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watch config writes and both handshakes, values seen are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.write_reg(i_cfg_addr, i_cfg_wdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_index(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_value(m_axis_tdata);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[adsr_envelope_table_entry] ERROR");
        $finish;
    end

    // offer one index, with a random gap first, and return at its handshake edge
    task automatic send_index(input logic [IDX_W-1:0] idx);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IDX_W'($urandom_range(255));
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct) begin
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= idx;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // stop sending and wait for every owed result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.waiting()) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [GAIN_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // all five registers plus one spare index, only while nothing is in flight
    task automatic set_envelope(input logic [GAIN_W-1:0] attack, input logic [GAIN_W-1:0] decay,
                                input logic [GAIN_W-1:0] sustain, input logic [GAIN_W-1:0] rel,
                                input logic [GAIN_W-1:0] gain);
        write_reg(REG_ATTACK_LEN, attack);
        write_reg(REG_DECAY_LEN, decay);
        write_reg(REG_SUSTAIN_LEVEL, sustain);
        write_reg(REG_RELEASE_LEN, rel);
        write_reg(REG_GAIN_FACTOR, gain);
        write_reg(ADDR_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                  GAIN_W'($urandom_range(16'hFFFF)));
        i_cfg_we <= 1'b0;
    endtask

    // 8-bit setting biased to the ends, junk in the upper byte to check masking
    function automatic logic [GAIN_W-1:0] pick_len();
        logic [AMP_W-1:0] v;
        case ($urandom_range(3))
            0:       v = 8'd0;
            1:       v = 8'd255;
            default: v = AMP_W'($urandom_range(255));
        endcase
        return {8'($urandom_range(255)), v};
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(4))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd256;
            default: return GAIN_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    initial begin
        int unsigned pause_at;
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: no attack or decay, full sustain, zero release at the last index
        send_index(8'd0);
        send_index(8'd128);
        send_index(8'd255);
        drain_results();

        // ordinary shape with every segment present, spare indexes written with junk
        for (int a = REG_SPARE_LO; a <= REG_SPARE_HI; a++) begin
            write_reg(a[ADDR_W-1:0], 16'hFFFF);
        end
        set_envelope(16'd10, 16'd20, 16'd100, 16'd30, 16'd300);
        send_index(8'd0);
        send_index(8'd5);
        send_index(8'd10);
        send_index(8'd29);
        send_index(8'd30);
        send_index(8'd100);
        send_index(8'd224);
        send_index(8'd225);
        send_index(8'd240);
        send_index(8'd255);
        drain_results();

        // decay end wraps, upper byte of sustain masked off, full release, top gain
        set_envelope(16'd200, 16'd100, 16'hFF37, 16'd255, 16'hFFFF);
        send_index(8'd0);
        send_index(8'd199);
        send_index(8'd200);
        send_index(8'd255);
        drain_results();

        // longest attack and decay, zero sustain, one release step, zero gain
        set_envelope(16'd255, 16'd255, 16'd0, 16'd1, 16'd0);
        send_index(8'd254);
        send_index(8'd255);
        drain_results();

        // no attack, longest decay down to zero, product at its largest
        set_envelope(16'd0, 16'd255, 16'd0, 16'd0, 16'hFFFF);
        send_index(8'd0);
        send_index(8'd1);
        send_index(8'd254);
        send_index(8'd255);
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_envelope(pick_len(), pick_len(), pick_len(), pick_len(), pick_gain());
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin src_idle_pct = 7; sink_stall_pct = 7; end
            endcase
            pause_at = $urandom_range(90, 10);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == pause_at) begin
                    drain_results();
                end
                send_index(IDX_W'($urandom_range(255)));
            end
            drain_results();
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.mismatches == 0) begin
            $display("[adsr_envelope_table_entry] OK");
        end else begin
            $display("[adsr_envelope_table_entry] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/aet_pkg.sv
design/aet_front.sv
design/aet_queue.sv
design/aet_back.sv
design/adsr_envelope_table_entry.sv
design/aet_checker.sv
verif/tb_adsr_envelope_table_entry.sv
